// File: src/exsc_pkg.sv
// ----------------------------------------------------------------------------
// exsc_pkg
// Shared constants and types for the exchange sort block.
// ----------------------------------------------------------------------------
package exsc_pkg;

   localparam int MaxElems     = 64;
   localparam int ValueBits    = 16;
   localparam int IdxBits      = 6;
   localparam int CntBits      = 7;
   localparam int CmpBits      = 11;
   localparam int MoveBits     = 13;
   localparam int MovesPerSwap = 3;

   localparam int RspFieldBits = ValueBits + IdxBits + CmpBits + MoveBits;
   localparam int RspDataBits  = ((RspFieldBits + 7) / 8) * 8;
   localparam int RspPadBits   = RspDataBits - RspFieldBits;

   localparam logic ModeBubble = 1'b0;
   localparam logic ModeShaker = 1'b1;

   typedef logic [ValueBits-1:0] value_type;
   typedef logic [IdxBits-1:0]   idx_type;
   typedef logic [CntBits-1:0]   cnt_type;

endpackage

// File: src/exchange_sort_with_counts.sv
// ----------------------------------------------------------------------------
// exchange_sort_with_counts
// Loads a set of signed values, sorts it ascending by bubble or cocktail
// shaker sort, and streams the result with comparison and move counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one value per transfer; req_tlast closes the set and starts
//   the sort. Up to 64 values are kept; extra values are dropped and flagged
//   in rsp_tuser for every result of that set.
//   csr_we/csr_wdata select the sort: 0 bubble, 1 cocktail shaker (reset 1).
//   rsp_* returns one transfer per element in ascending order; rsp_tlast marks
//   the final element. Each carries the position and the final counts.
// Timing:
//   Loading takes one cycle per value. Sorting uses one comparator over the
//   element RAM, one compare per cycle: each pass adds a start read, a carry
//   load and a write-back to its compares. Output reads each element from the
//   RAM into the result register and starts the next read only once that
//   result has been taken. req_tready is low from the last value until the
//   final result has been taken.
// Reset:
//   Synchronous reset empties the set, clears the counts and selects shaker.
//   A stalled rsp_tready holds the current result and pauses the block.
// ----------------------------------------------------------------------------
module exchange_sort_with_counts (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [exsc_pkg::ValueBits-1:0] req_tdata,   // value
   input  logic                           req_tlast,   // last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // sorted_value, position, compare_count, move_count, zero pad
   output logic [exsc_pkg::RspDataBits-1:0] rsp_tdata,
   output logic                           rsp_tlast,   // end_of_set
   output logic                           rsp_tuser,   // overflow
   input  logic                           csr_we,
   input  logic                           csr_wdata    // sort_mode
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BWD_START,
      ST_BWD_LOAD,
      ST_BWD_CMP,
      ST_BWD_END,
      ST_FWD_START,
      ST_FWD_LOAD,
      ST_FWD_CMP,
      ST_FWD_END,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_HOLD
   } state_type;

   localparam exsc_pkg::cnt_type CntOne  = exsc_pkg::CntBits'(1);
   localparam exsc_pkg::cnt_type CntMax  = exsc_pkg::CntBits'(exsc_pkg::MaxElems);
   localparam exsc_pkg::idx_type IdxOne  = exsc_pkg::IdxBits'(1);
   localparam exsc_pkg::idx_type IdxTwo  = exsc_pkg::IdxBits'(2);
   localparam logic [exsc_pkg::CmpBits-1:0]  CmpOne  = exsc_pkg::CmpBits'(1);
   localparam logic [exsc_pkg::MoveBits-1:0] MoveInc =
      exsc_pkg::MoveBits'(exsc_pkg::MovesPerSwap);

   state_type                       state_ff, state_in;
   logic                            mode_ff, mode_in;
   exsc_pkg::cnt_type               count_ff, count_in;
   logic                            dropped_ff, dropped_in;
   exsc_pkg::cnt_type               lo_ff, lo_in;
   exsc_pkg::cnt_type               hi_ff, hi_in;
   exsc_pkg::cnt_type               last_ff, last_in;
   exsc_pkg::idx_type               j_ff, j_in;
   exsc_pkg::idx_type               k_ff, k_in;
   logic [exsc_pkg::CmpBits-1:0]    cmp_ff, cmp_in;
   logic [exsc_pkg::MoveBits-1:0]   mov_ff, mov_in;
   exsc_pkg::value_type             carry_ff, carry_in;
   exsc_pkg::value_type             rsp_value_ff, rsp_value_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            ram_we;
   exsc_pkg::idx_type               ram_waddr;
   exsc_pkg::value_type             ram_wdata;
   exsc_pkg::idx_type               ram_raddr;
   exsc_pkg::value_type             ram_rdata;

   logic                            req_xfer;
   logic                            rsp_xfer;
   logic                            store_item;
   exsc_pkg::cnt_type               n_new;
   logic                            fwd_swap;
   logic                            bwd_swap;
   logic                            end_of_set;

   exsc_ram #(
      .Width(exsc_pkg::ValueBits),
      .Depth(exsc_pkg::MaxElems)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign store_item = (count_ff < CntMax);
   assign n_new      = store_item ? count_ff + CntOne : count_ff;
   assign fwd_swap   = ($signed(carry_ff) > $signed(ram_rdata));
   assign bwd_swap   = ($signed(carry_ff) < $signed(ram_rdata));
   assign end_of_set = ({1'b0, k_ff} == (count_ff - CntOne));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{exsc_pkg::RspPadBits{1'b0}}, mov_ff, cmp_ff, k_ff, rsp_value_ff};
   assign rsp_tlast  = end_of_set;
   assign rsp_tuser  = dropped_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      last_in      = last_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      cmp_in       = cmp_ff;
      mov_in       = mov_ff;
      carry_in     = carry_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = carry_ff;
      ram_raddr    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (store_item) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[exsc_pkg::IdxBits-1:0];
                  ram_wdata = req_tdata;
               end else begin
                  dropped_in = 1'b1;
               end
               count_in = n_new;
               if (req_tlast) begin
                  cmp_in  = '0;
                  mov_in  = '0;
                  lo_in   = '0;
                  hi_in   = n_new - CntOne;
                  last_in = n_new;
                  k_in    = '0;
                  if (mode_ff == exsc_pkg::ModeShaker) begin
                     state_in = ST_BWD_START;
                  end else if (n_new == CntOne) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     state_in = ST_FWD_START;
                  end
               end
            end
         end
         ST_BWD_START: begin
            if (hi_ff > lo_ff) begin
               ram_raddr = hi_ff[exsc_pkg::IdxBits-1:0];
               j_in      = hi_ff[exsc_pkg::IdxBits-1:0];
               state_in  = ST_BWD_LOAD;
            end else begin
               lo_in    = last_ff;
               state_in = ST_FWD_START;
            end
         end
         ST_BWD_LOAD: begin
            carry_in  = ram_rdata;
            ram_raddr = j_ff - IdxOne;
            state_in  = ST_BWD_CMP;
         end
         ST_BWD_CMP: begin
            cmp_in    = cmp_ff + CmpOne;
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (bwd_swap) begin
               ram_wdata = ram_rdata;
               mov_in    = mov_ff + MoveInc;
               last_in   = {1'b0, j_ff};
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            j_in = j_ff - IdxOne;
            if ({1'b0, j_ff} > lo_ff + CntOne) begin
               ram_raddr = j_ff - IdxTwo;
            end else begin
               state_in = ST_BWD_END;
            end
         end
         ST_BWD_END: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[exsc_pkg::IdxBits-1:0];
            ram_wdata = carry_ff;
            lo_in     = last_ff;
            state_in  = ST_FWD_START;
         end
         ST_FWD_START: begin
            if (lo_ff < hi_ff) begin
               ram_raddr = lo_ff[exsc_pkg::IdxBits-1:0];
               j_in      = lo_ff[exsc_pkg::IdxBits-1:0];
               state_in  = ST_FWD_LOAD;
            end else begin
               hi_in    = last_ff;
               state_in = ST_EMIT_RD;
            end
         end
         ST_FWD_LOAD: begin
            carry_in  = ram_rdata;
            ram_raddr = j_ff + IdxOne;
            state_in  = ST_FWD_CMP;
         end
         ST_FWD_CMP: begin
            cmp_in    = cmp_ff + CmpOne;
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            if (fwd_swap) begin
               ram_wdata = ram_rdata;
               mov_in    = mov_ff + MoveInc;
               last_in   = {1'b0, j_ff};
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            j_in = j_ff + IdxOne;
            if ({1'b0, j_ff} + CntOne < hi_ff) begin
               ram_raddr = j_ff + IdxTwo;
            end else begin
               state_in = ST_FWD_END;
            end
         end
         ST_FWD_END: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff[exsc_pkg::IdxBits-1:0];
            ram_wdata = carry_ff;
            if (mode_ff == exsc_pkg::ModeShaker) begin
               hi_in    = last_ff;
               state_in = (lo_ff < last_ff) ? ST_BWD_START : ST_EMIT_RD;
            end else begin
               hi_in    = hi_ff - CntOne;
               state_in = (hi_ff == CntOne) ? ST_EMIT_RD : ST_FWD_START;
            end
         end
         ST_EMIT_RD: begin
            ram_raddr = k_ff;
            state_in  = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            rsp_value_in = ram_rdata;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               if (end_of_set) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  k_in      = k_ff + IdxOne;
                  ram_raddr = k_ff + IdxOne;
                  state_in  = ST_EMIT_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= exsc_pkg::ModeShaker;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         last_ff      <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         cmp_ff       <= '0;
         mov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         last_ff      <= last_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         cmp_ff       <= cmp_in;
         mov_ff       <= mov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

// File: src/exsc_ram.sv
// ----------------------------------------------------------------------------
// exsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module exsc_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sim/exchange_sort_with_counts_tb.sv
// ----------------------------------------------------------------------------
// exchange_sort_with_counts_tb
// Streams sets of signed values into the sort block under both sort modes,
// predicts each sorted set with its comparison and move counts, and checks
// every result transfer field by field. Both stream sides idle at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module exchange_sort_with_counts_tb;

   localparam int CycleLimit = 500000;
   localparam int HoldCycles = 400;

   typedef struct {
      exsc_pkg::value_type                   value;
      logic                                  last;
   } load_item_type;

   typedef struct {
      exsc_pkg::value_type                   value;
      exsc_pkg::idx_type                     position;
      logic                                  end_of_set;
      logic [exsc_pkg::CmpBits-1:0]          compares;
      logic [exsc_pkg::MoveBits-1:0]         moves;
      logic                                  overflow;
   } sorted_item_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [exsc_pkg::ValueBits-1:0]   req_tdata = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [exsc_pkg::RspDataBits-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;
   logic                             csr_we = 1'b0;
   logic                             csr_wdata = 1'b0;

   load_item_type   load_queue[$];
   sorted_item_type expected_sorted[$];

   logic signed [exsc_pkg::ValueBits-1:0] held_values [exsc_pkg::MaxElems];
   int           held_count = 0;
   logic         held_dropped = 1'b0;
   logic         sort_mode_model = exsc_pkg::ModeShaker;
   int           compare_tally;
   int           move_tally;

   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           idle_pct = 34;
   bit           hold_request = 1'b0;
   bit           hold_done = 1'b0;
   int           hold_left = 0;

   exchange_sort_with_counts i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sort predictor
   // ------------------------------------------------------------------------
   task automatic swap_held(input int a, input int b);
      logic signed [exsc_pkg::ValueBits-1:0] tmp;
      tmp = held_values[a];
      held_values[a] = held_values[b];
      held_values[b] = tmp;
      move_tally += exsc_pkg::MovesPerSwap;
   endtask

   task automatic sort_held_set(input int n);
      int lo;
      int hi;
      int last_swap;
      int j;
      int pass;
      compare_tally = 0;
      move_tally = 0;
      if (sort_mode_model == exsc_pkg::ModeShaker) begin
         lo = 0;
         hi = n - 1;
         last_swap = n;
         do begin
            for (j = hi; j > lo; j--) begin
               compare_tally++;
               if (held_values[j] < held_values[j-1]) begin
                  swap_held(j, j - 1);
                  last_swap = j;
               end
            end
            lo = last_swap;
            for (j = lo; j < hi; j++) begin
               compare_tally++;
               if (held_values[j] > held_values[j+1]) begin
                  swap_held(j, j + 1);
                  last_swap = j;
               end
            end
            hi = last_swap;
         end while (lo < hi);
      end else begin
         for (pass = 0; pass < n - 1; pass++) begin
            for (j = 0; j < n - pass - 1; j++) begin
               compare_tally++;
               if (held_values[j] > held_values[j+1]) swap_held(j, j + 1);
            end
         end
      end
   endtask

   task automatic accept_value(input exsc_pkg::value_type v, input logic is_last);
      int n;
      sorted_item_type r;
      if (held_count < exsc_pkg::MaxElems) begin
         held_values[held_count] = v;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (is_last) begin
         n = held_count;
         sort_held_set(n);
         for (int k = 0; k < n; k++) begin
            r.value      = held_values[k];
            r.position   = exsc_pkg::idx_type'(k);
            r.end_of_set = (k == n - 1);
            r.compares   = compare_tally[exsc_pkg::CmpBits-1:0];
            r.moves      = move_tally[exsc_pkg::MoveBits-1:0];
            r.overflow   = held_dropped;
            expected_sorted.push_back(r);
         end
         held_count = 0;
         held_dropped = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      load_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) accept_value(req_tdata, req_tlast);
         if (load_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            it = load_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.value;
            req_tlast  <= it.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor and result-side flow control
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // long result-side hold, started once the first result of that set shows up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_request && !hold_done && rsp_tvalid) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      sorted_item_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sorted.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual tdata 0x%0h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               e = expected_sorted.pop_front();
               check_field("sorted_value", 32'(e.value),
                           32'(rsp_tdata[exsc_pkg::ValueBits-1:0]));
               check_field("position", 32'(e.position),
                           32'(rsp_tdata[exsc_pkg::ValueBits +: exsc_pkg::IdxBits]));
               check_field("end_of_set", 32'(e.end_of_set), 32'(rsp_tlast));
               check_field("compare_count", 32'(e.compares),
                           32'(rsp_tdata[exsc_pkg::ValueBits+exsc_pkg::IdxBits +:
                                         exsc_pkg::CmpBits]));
               check_field("move_count", 32'(e.moves),
                           32'(rsp_tdata[exsc_pkg::ValueBits+exsc_pkg::IdxBits+
                                         exsc_pkg::CmpBits +: exsc_pkg::MoveBits]));
               check_field("overflow", 32'(e.overflow), 32'(rsp_tuser));
            end
         end
         if (hold_left > 0 || (hold_request && !hold_done && rsp_tvalid)) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_set(input int size, input int style);
      load_item_type it;
      exsc_pkg::value_type base;
      base = exsc_pkg::value_type'($urandom);
      for (int k = 0; k < size; k++) begin
         case (style)
            0: it.value = exsc_pkg::value_type'($urandom);
            1: it.value = exsc_pkg::value_type'($urandom_range(8) - 4);
            2: begin
               case ($urandom_range(3))
                  0: it.value = 16'h8000;
                  1: it.value = 16'h7fff;
                  2: it.value = 16'h0000;
                  default: it.value = 16'hffff;
               endcase
            end
            3: it.value = base + exsc_pkg::value_type'(k * $urandom_range(1, 9));
            default: it.value = base - exsc_pkg::value_type'(k * $urandom_range(1, 9));
         endcase
         it.last = (k == size - 1);
         load_queue.push_back(it);
      end
   endtask

   task automatic queue_values(input exsc_pkg::value_type vals[$]);
      load_item_type it;
      foreach (vals[k]) begin
         it.value = vals[k];
         it.last  = (k == vals.size() - 1);
         load_queue.push_back(it);
      end
   endtask

   task automatic queue_random_sets(input int budget);
      int size;
      while (budget > 0) begin
         if ($urandom_range(14) == 0) size = $urandom_range(60, 70);
         else if ($urandom_range(4) == 0) size = $urandom_range(11, 30);
         else size = $urandom_range(1, 10);
         queue_set(size, $urandom_range(4));
         budget -= size;
      end
   endtask

   task automatic drain_all();
      while (load_queue.size() != 0 || req_tvalid || expected_sorted.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_sort_mode(input logic mode);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      sort_mode_model = mode;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shaker (reset mode): single, extremes, duplicates, reversed
      queue_values('{16'h8000});
      queue_values('{16'h7fff, 16'h8000});
      queue_values('{16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000});
      queue_values('{16'h0005, 16'h0005, 16'h0005});
      queue_values('{16'h0003, 16'h0002, 16'h0001, 16'h0000});
      drain_all();

      write_sort_mode(exsc_pkg::ModeBubble);
      queue_values('{16'h7fff, 16'h8000});
      queue_values('{16'h0004, 16'h0003, 16'h0002, 16'h0001, 16'h0000});
      queue_values('{16'hffff});
      drain_all();

      // bubble: store filled, the last value is dropped
      queue_set(65, 0);
      queue_random_sets(25);
      drain_all();

      write_sort_mode(exsc_pkg::ModeShaker);
      hold_request = 1'b1;
      queue_set(68, 0);
      queue_random_sets(25);
      drain_all();

      write_sort_mode(exsc_pkg::ModeBubble);
      idle_pct = 0;
      queue_random_sets(65);
      drain_all();

      write_sort_mode(exsc_pkg::ModeShaker);
      idle_pct = 34;
      queue_random_sets(65);
      drain_all();

      write_sort_mode(exsc_pkg::ModeBubble);
      queue_set(64, 4);
      queue_random_sets(20);
      drain_all();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_sorted.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
src/exsc_pkg.sv
src/exsc_ram.sv
src/exchange_sort_with_counts.sv
sim/exchange_sort_with_counts_tb.sv
